// ===== design/ghi_pkg.sv =====
// Shared types, widths and constants for the gyro heading integrator.
// No dependencies; used by ghi_mul, ghi_ctrl and gyro_heading_integrator.
package ghi_pkg;

  localparam int RATE_W    = 16;
  localparam int TIME_W    = 32;
  localparam int HEAD_W    = 64;
  localparam int WEIGHT_W  = 16;
  localparam int DBAND_W   = 15;
  localparam int DINT_W    = 20;
  localparam int FACC_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_INTERVAL = 2'd2;

  localparam logic [WEIGHT_W-1:0] FILTER_WEIGHT_RST    = 16'd19661;
  localparam logic [DBAND_W-1:0]  DEAD_BAND_RST        = 15'd48;
  localparam logic [DINT_W-1:0]   DEFAULT_INTERVAL_RST = 20'd1000;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_SEL_NONE = 2'd0,
    MUL_SEL_W    = 2'd1,
    MUL_SEL_C    = 2'd2,
    MUL_SEL_DT   = 2'd3
  } mul_sel_t;

  // filter accumulator limits, Q16.16 of the int16 range
  localparam logic signed [47:0] FACC_MAX = 48'sh0000_7FFF_0000;
  localparam logic signed [47:0] FACC_MIN = -48'sh0000_8000_0000;

  localparam logic signed [HEAD_W-1:0] HEAD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [HEAD_W-1:0] HEAD_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic     busy;
    logic     take;
    mul_sel_t mul_sel;
    logic     mul_w;
    logic     mul_c;
    logic     filt;
    logic     rate;
    logic     mul_dt;
    logic     commit;
  } ctrl_t;

endpackage

// ===== design/ghi_mul.sv =====
// Shared signed multiplier used for filter weighting and rate times interval.
// Depends on ghi_pkg for operand widths.
module ghi_mul (
  input  logic signed [ghi_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [ghi_pkg::MUL_B_W-1:0] op_b,
  output logic signed [ghi_pkg::MUL_P_W-1:0] prod
);

  assign prod = op_a * op_b;

endmodule

// ===== design/ghi_ctrl.sv =====
// Step sequencer for the gyro heading integrator.
// Depends on ghi_pkg for the control struct and multiplier selects.
module ghi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_free,
  output ghi_pkg::ctrl_t ctrl
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MULW  = 7'b0000010,
    S_MULC  = 7'b0000100,
    S_FILT  = 7'b0001000,
    S_RATE  = 7'b0010000,
    S_MULDT = 7'b0100000,
    S_ADD   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MULW;
      S_MULW:  state_nxt = S_MULC;
      S_MULC:  state_nxt = S_FILT;
      S_FILT:  state_nxt = S_RATE;
      S_RATE:  state_nxt = S_MULDT;
      S_MULDT: state_nxt = S_ADD;
      S_ADD:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctrl.busy    = (state_r != S_IDLE);
    ctrl.take    = (state_r == S_IDLE) && in_valid;
    ctrl.mul_w   = (state_r == S_MULW);
    ctrl.mul_c   = (state_r == S_MULC);
    ctrl.filt    = (state_r == S_FILT);
    ctrl.rate    = (state_r == S_RATE);
    ctrl.mul_dt  = (state_r == S_MULDT);
    ctrl.commit  = (state_r == S_ADD) && out_free;
    case (state_r)
      S_MULW:  ctrl.mul_sel = ghi_pkg::MUL_SEL_W;
      S_MULC:  ctrl.mul_sel = ghi_pkg::MUL_SEL_C;
      S_MULDT: ctrl.mul_sel = ghi_pkg::MUL_SEL_DT;
      default: ctrl.mul_sel = ghi_pkg::MUL_SEL_NONE;
    endcase
  end

endmodule

// ===== design/gyro_heading_integrator.sv =====
// Top level of the gyro heading integrator: datapath, registers and ports.
// Depends on ghi_pkg, ghi_mul and ghi_ctrl.
//
// One z-axis rate sample with its microsecond timestamp goes in per
// transaction and one result (saturating 64-bit heading plus the filtered,
// dead-banded rate) comes out per transaction. A new sample is taken only
// once the previous one has finished and the block is idle again. One
// shared 18x33 signed multiplier is used three times; the steps in order
// are new-sample weight, old-value weight, filter clamp, rate rounding plus
// dead band and interval, rate times interval, and the saturating heading
// add. in_stall stays high for the whole sequence. The finished result sits
// in an output register; the block waits in its final step only while a
// previous result still waits to be taken. Configuration writes are always
// ready and should be made while no sample is in progress.
module gyro_heading_integrator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ghi_pkg::RATE_W-1:0]     in_rate_sample,
  input  logic        [ghi_pkg::TIME_W-1:0]     in_sample_time,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ghi_pkg::HEAD_W-1:0]     out_heading,
  output logic signed [ghi_pkg::RATE_W-1:0]     out_filtered_rate,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [ghi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ghi_pkg::CFG_DAT_W-1:0]  cfg_data
);

  ghi_pkg::ctrl_t ctrl;
  logic           out_free;

  // configuration registers
  logic [ghi_pkg::WEIGHT_W-1:0] weight_r;
  logic [ghi_pkg::DBAND_W-1:0]  dband_r;
  logic [ghi_pkg::DINT_W-1:0]   dint_r;

  // state
  logic signed [ghi_pkg::FACC_W-1:0] facc_r, facc_nxt;
  logic        [ghi_pkg::TIME_W-1:0] prev_time_r;
  logic signed [ghi_pkg::HEAD_W-1:0] heading_r;

  // per-sample working registers
  logic signed [ghi_pkg::RATE_W-1:0] x_r;
  logic        [ghi_pkg::TIME_W-1:0] time_r;
  logic signed [ghi_pkg::HEAD_W-1:0] sum_r, sum_nxt;
  logic signed [ghi_pkg::RATE_W-1:0] rate_r, rate_nxt;
  logic        [ghi_pkg::TIME_W-1:0] dt_r, dt_nxt;

  // output register
  logic                              out_valid_r;
  logic signed [ghi_pkg::HEAD_W-1:0] out_heading_r;
  logic signed [ghi_pkg::RATE_W-1:0] out_rate_r;

  // multiplier operands
  logic signed [ghi_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ghi_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ghi_pkg::MUL_P_W-1:0] mul_p;
  logic signed [ghi_pkg::HEAD_W-1:0]  mul_p64;

  // filter and rate intermediates
  logic signed [47:0]                 q;
  logic signed [32:0]                 rnd;
  logic signed [16:0]                 r17;
  logic signed [16:0]                 r_mag;
  logic signed [ghi_pkg::RATE_W-1:0]  r_clamp;
  logic        [ghi_pkg::TIME_W-1:0]  diff;

  // heading add
  logic signed [ghi_pkg::HEAD_W-1:0]  head_sum, head_sat;
  logic                               head_ovf;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = ctrl.busy;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_heading       = out_heading_r;
  assign out_filtered_rate = out_rate_r;

  ghi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // operand selection for the shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      ghi_pkg::MUL_SEL_W: begin
        mul_a = $signed({2'b00, weight_r});
        mul_b = $signed({{17{x_r[15]}}, x_r});
      end
      ghi_pkg::MUL_SEL_C: begin
        mul_a = $signed({1'b0, 17'h10000 - {1'b0, weight_r}});
        mul_b = $signed({facc_r[31], facc_r});
      end
      ghi_pkg::MUL_SEL_DT: begin
        mul_a = $signed({{2{rate_r[15]}}, rate_r});
        mul_b = $signed({1'b0, dt_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ghi_mul u_mul (
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  assign mul_p64 = $signed({{(ghi_pkg::HEAD_W-ghi_pkg::MUL_P_W){mul_p[ghi_pkg::MUL_P_W-1]}},
                            mul_p});

  // weighted sum: new sample shifted to Q16.16 plus rounding, then old value; later rate times interval
  always_comb begin
    sum_nxt = sum_r;
    if (ctrl.mul_w) begin
      sum_nxt = (mul_p64 <<< 16) + 64'sd32768;
    end else if (ctrl.mul_c) begin
      sum_nxt = sum_r + mul_p64;
    end else if (ctrl.mul_dt) begin
      sum_nxt = mul_p64;
    end
  end

  // floor divide by 2^16 and clamp to the Q16.16 int16 range
  always_comb begin
    q = sum_r[63:16];
    if (q > ghi_pkg::FACC_MAX) begin
      facc_nxt = ghi_pkg::FACC_MAX[31:0];
    end else if (q < ghi_pkg::FACC_MIN) begin
      facc_nxt = ghi_pkg::FACC_MIN[31:0];
    end else begin
      facc_nxt = q[31:0];
    end
  end

  // round to whole units, clamp, apply dead band; derive the interval
  always_comb begin
    rnd   = $signed({facc_r[31], facc_r}) + 33'sd32768;
    r17   = rnd[32:16];
    if (r17 > 17'sd32767) begin
      r_clamp = 16'sh7FFF;
    end else if (r17 < -17'sd32768) begin
      r_clamp = 16'sh8000;
    end else begin
      r_clamp = r17[15:0];
    end
    r_mag = r_clamp[15] ? -$signed({r_clamp[15], r_clamp})
                        : $signed({r_clamp[15], r_clamp});
    if (r_mag < $signed({2'b00, dband_r})) begin
      rate_nxt = '0;
    end else begin
      rate_nxt = r_clamp;
    end
    diff   = time_r - prev_time_r;
    dt_nxt = (diff == '0) ? {{(ghi_pkg::TIME_W-ghi_pkg::DINT_W){1'b0}}, dint_r} : diff;
  end

  // saturating heading add
  always_comb begin
    head_sum = heading_r + sum_r;
    head_ovf = (heading_r[63] == sum_r[63]) && (head_sum[63] != heading_r[63]);
    if (head_ovf) begin
      head_sat = heading_r[63] ? ghi_pkg::HEAD_MIN : ghi_pkg::HEAD_MAX;
    end else begin
      head_sat = head_sum;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= ghi_pkg::FILTER_WEIGHT_RST;
      dband_r     <= ghi_pkg::DEAD_BAND_RST;
      dint_r      <= ghi_pkg::DEFAULT_INTERVAL_RST;
      facc_r      <= '0;
      prev_time_r <= '0;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ghi_pkg::REG_FILTER_WEIGHT:    weight_r <= cfg_data[ghi_pkg::WEIGHT_W-1:0];
          ghi_pkg::REG_DEAD_BAND:        dband_r  <= cfg_data[ghi_pkg::DBAND_W-1:0];
          ghi_pkg::REG_DEFAULT_INTERVAL: dint_r   <= cfg_data[ghi_pkg::DINT_W-1:0];
          default: ;  // drop writes to unknown indexes
        endcase
      end
      if (ctrl.filt) begin
        facc_r <= facc_nxt;
      end
      if (ctrl.rate) begin
        prev_time_r <= time_r;
      end
      if (ctrl.commit) begin
        heading_r   <= head_sat;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      x_r    <= in_rate_sample;
      time_r <= in_sample_time;
    end
    sum_r <= sum_nxt;
    if (ctrl.rate) begin
      rate_r <= rate_nxt;
      dt_r   <= dt_nxt;
    end
    if (ctrl.commit) begin
      out_heading_r <= head_sat;
      out_rate_r    <= rate_r;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for gyro_heading_integrator: directed table, random phases
// and a closing run of full-scale samples, checked against an in-bench predictor
// or, for typed rows, hand-worked results. Depends on ghi_pkg and the RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Index the block has no register behind; writes to it must be dropped.
  localparam logic [ghi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int DIRECTED_ROWS = 25;
  localparam int PHASES        = 6;
  localparam int PHASE_SAMPLES = 260;
  localparam int DRAIN_CYCLES  = 20;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic signed [ghi_pkg::HEAD_W-1:0] heading;
    logic signed [ghi_pkg::RATE_W-1:0] rate;
  } heading_result_t;

  // One line of the directed table: either a sample or a register write.
  // want_* holds a hand-worked result, used only where typed is set.
  typedef struct packed {
    row_kind_t                         kind;
    logic [ghi_pkg::CFG_IDX_W-1:0]     index;
    logic [ghi_pkg::CFG_DAT_W-1:0]     data;
    logic signed [ghi_pkg::RATE_W-1:0] rate;
    logic [ghi_pkg::TIME_W-1:0]        stamp;
    logic                              typed;
    logic signed [ghi_pkg::HEAD_W-1:0] want_heading;
    logic signed [ghi_pkg::RATE_W-1:0] want_rate;
  } stim_row_t;

  // Clock, reset and every block input start at known values.
  logic                              clk               = 1'b0;
  logic                              rst_n             = 1'b0;
  logic                              in_valid          = 1'b0;
  logic                              in_stall;
  logic signed [ghi_pkg::RATE_W-1:0] in_rate_sample    = '0;
  logic [ghi_pkg::TIME_W-1:0]        in_sample_time    = '0;
  logic                              out_valid;
  logic                              out_stall         = 1'b0;
  logic signed [ghi_pkg::HEAD_W-1:0] out_heading;
  logic signed [ghi_pkg::RATE_W-1:0] out_filtered_rate;
  logic                              cfg_valid         = 1'b0;
  logic                              cfg_ready;
  logic [ghi_pkg::CFG_IDX_W-1:0]     cfg_index         = '0;
  logic [ghi_pkg::CFG_DAT_W-1:0]     cfg_data          = '0;

  // Predictor copy of the registers and the integrator state, at reset values.
  logic [ghi_pkg::WEIGHT_W-1:0]      weight_q    = ghi_pkg::FILTER_WEIGHT_RST;
  logic [ghi_pkg::DBAND_W-1:0]       band_q      = ghi_pkg::DEAD_BAND_RST;
  logic [ghi_pkg::DINT_W-1:0]        interval_q  = ghi_pkg::DEFAULT_INTERVAL_RST;
  logic signed [ghi_pkg::FACC_W-1:0] filt_acc    = '0;
  logic [ghi_pkg::TIME_W-1:0]        prev_stamp  = '0;
  logic signed [ghi_pkg::HEAD_W-1:0] heading_acc = '0;

  heading_result_t pending_headings[$];
  int              failures   = 0;
  int unsigned     stall_pct  = 25;
  int              stall_left = 0;

  // Directed table. Special cases covered in order: first sample measured
  // from timestamp zero, repeated timestamp taking the default interval,
  // rate under the dead band, full-scale rates, a backwards timestamp that
  // wraps into a huge interval, maximum weight, a wrap across zero read as a
  // short interval, maximum dead band, zero default interval, maximum
  // default interval, zero weight holding the filter, a write to an unknown
  // index, and the minimum nonzero weight and interval.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, '0, '0, 16'sd0, 32'd0, 1'b1, 64'sd0, 16'sd0},
    '{ROW_SAMPLE, '0, '0, 16'sd100, 32'd0, 1'b1, 64'sd0, 16'sd0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 32'd5000, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sh8000, 32'd4000, 1'b0, '0, '0},
    '{ROW_WRITE, ghi_pkg::REG_FILTER_WEIGHT, 20'hFFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sh8000, 32'hFFFF_FFF0, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sh8000, 32'h0000_0010, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 32'h0000_0010, 1'b0, '0, '0},
    '{ROW_WRITE, ghi_pkg::REG_DEAD_BAND, 20'hFFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sd1234, 32'h0000_0020, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 32'h0000_0030, 1'b0, '0, '0},
    '{ROW_WRITE, ghi_pkg::REG_DEFAULT_INTERVAL, 20'h00000, '0, '0, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 32'h0000_0030, 1'b0, '0, '0},
    '{ROW_WRITE, ghi_pkg::REG_DEFAULT_INTERVAL, 20'hFFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sh8000, 32'h0000_0030, 1'b0, '0, '0},
    '{ROW_WRITE, ghi_pkg::REG_FILTER_WEIGHT, 20'h00000, '0, '0, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 32'h0000_0040, 1'b0, '0, '0},
    '{ROW_WRITE, REG_UNUSED, 20'hFFFFF, '0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, ghi_pkg::REG_DEAD_BAND, 20'h00000, '0, '0, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'shFFFF, 32'hFFFF_FFFF, 1'b0, '0, '0},
    '{ROW_WRITE, ghi_pkg::REG_FILTER_WEIGHT, 20'h00001, '0, '0, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sd0, 32'h8000_0000, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'shFFFF, 32'h8000_0000, 1'b0, '0, '0},
    '{ROW_WRITE, ghi_pkg::REG_DEFAULT_INTERVAL, 20'h00001, '0, '0, 1'b0, '0, '0},
    '{ROW_SAMPLE, '0, '0, 16'sd1, 32'h8000_0000, 1'b0, '0, '0}
  };

  gyro_heading_integrator uut (.*);

  always #1 clk = ~clk;

  // Advance the predictor by one accepted sample and return the result the
  // block owes for it. Arithmetic is carried in 64 bits, and the heading add
  // in 65, so nothing overflows before the explicit clamps.
  function automatic heading_result_t integrate_rate(
      input logic signed [ghi_pkg::RATE_W-1:0] rate,
      input logic [ghi_pkg::TIME_W-1:0]        stamp);
    longint                          w, x, old, sum, acc, r, mag, ticks, step;
    logic [ghi_pkg::TIME_W-1:0]      dt;
    logic signed [ghi_pkg::HEAD_W:0] wide;
    heading_result_t                 res;
    w   = longint'(weight_q);
    x   = longint'(rate);
    old = longint'(filt_acc);
    // Convex blend in Q16.16, round half up, then floor by arithmetic shift.
    sum = w * (x <<< 16) + (65536 - w) * old + 32768;
    acc = sum >>> 16;
    if (acc > ghi_pkg::FACC_MAX) acc = longint'(ghi_pkg::FACC_MAX);
    if (acc < ghi_pkg::FACC_MIN) acc = longint'(ghi_pkg::FACC_MIN);
    filt_acc = acc[ghi_pkg::FACC_W-1:0];
    // Round to whole rate units, then apply the dead band on magnitude.
    r   = (acc + 32768) >>> 16;
    mag = (r < 0) ? -r : r;
    if (mag < longint'(band_q)) r = 0;
    // Interval wraps mod 2^32; a repeated timestamp takes the default.
    dt = stamp - prev_stamp;
    if (dt == '0) dt = ghi_pkg::TIME_W'(interval_q);
    prev_stamp = stamp;
    ticks = longint'(dt);
    step  = r * ticks;
    // Add in 65 bits so the saturation decision sees the true sum.
    wide = {heading_acc[ghi_pkg::HEAD_W-1], heading_acc} + {step[63], step};
    if (wide > ghi_pkg::HEAD_MAX)      heading_acc = ghi_pkg::HEAD_MAX;
    else if (wide < ghi_pkg::HEAD_MIN) heading_acc = ghi_pkg::HEAD_MIN;
    else                               heading_acc = wide[ghi_pkg::HEAD_W-1:0];
    res.heading = heading_acc;
    res.rate    = r[ghi_pkg::RATE_W-1:0];
    return res;
  endfunction

  // Count and print every failure.
  function automatic void report(input string msg);
    failures++;
    $error("%s", msg);
  endfunction

  // Drive one sample, hold it until the block takes it, then queue what the
  // block must answer. Called at a rising edge; returns at the accepting edge
  // with in_valid still high so a back-to-back sample needs no second drive.
  task automatic send_sample(input logic signed [ghi_pkg::RATE_W-1:0] rate,
                             input logic [ghi_pkg::TIME_W-1:0] stamp,
                             input int unsigned gap,
                             input logic use_fixed,
                             input heading_result_t fixed);
    heading_result_t predicted;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rate_sample <= rate;
    in_sample_time <= stamp;
    do @(posedge clk); while (in_stall);
    predicted = integrate_rate(rate, stamp);
    pending_headings.push_back(use_fixed ? fixed : predicted);
  endtask

  // Drop the sample valid and hold until every queued result has arrived.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_headings.size() != 0);
  endtask

  // One register write transaction; mirror it into the predictor with the
  // same width truncation the block applies.
  task automatic write_reg(input logic [ghi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ghi_pkg::CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ghi_pkg::REG_FILTER_WEIGHT:    weight_q   = data[ghi_pkg::WEIGHT_W-1:0];
      ghi_pkg::REG_DEAD_BAND:        band_q     = data[ghi_pkg::DBAND_W-1:0];
      ghi_pkg::REG_DEFAULT_INTERVAL: interval_q = data[ghi_pkg::DINT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: check each transaction against the oldest expectation and
  // drive a stall pattern of mostly short bursts with the odd long one.
  always @(posedge clk) begin : result_check
    heading_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_headings.size() == 0) begin
          report($sformatf("result with nothing pending: heading %0d, filtered_rate %0d",
                           out_heading, out_filtered_rate));
        end else begin
          want = pending_headings.pop_front();
          if (out_heading !== want.heading)
            report($sformatf("heading: expected %0d, actual %0d", want.heading, out_heading));
          if (out_filtered_rate !== want.rate)
            report($sformatf("filtered_rate: expected %0d, actual %0d",
                             want.rate, out_filtered_rate));
        end
      end
      if (stall_left != 0)
        stall_left--;
      else if ($urandom_range(99) < stall_pct)
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    end
    out_stall <= rst_n && (stall_left != 0);
  end

  initial begin : stimulus
    stim_row_t                         row;
    heading_result_t                   fixed;
    logic signed [ghi_pkg::RATE_W-1:0] rate;
    logic [ghi_pkg::TIME_W-1:0]        stamp;
    logic [ghi_pkg::CFG_DAT_W-1:0]     setting;
    int unsigned                       gap_pct, gap;
    int                                n;
    fixed = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Writes only go in once the block has gone idle.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_until_drained();
        write_reg(row.index, row.data);
      end else begin
        fixed.heading = row.want_heading;
        fixed.rate    = row.want_rate;
        send_sample(row.rate, row.stamp, 0, row.typed, fixed);
      end
    end

    // Random phases, each under a fresh register setting. Upper data bits
    // beyond each register's width are randomized to exercise truncation.
    for (int p = 0; p < PHASES; p++) begin
      wait_until_drained();
      case ($urandom_range(4))
        0:       setting = '0;
        1:       setting = 20'h0FFFF;
        2:       setting = 20'h00001;
        default: setting = 20'($urandom_range(65535));
      endcase
      setting[ghi_pkg::CFG_DAT_W-1:ghi_pkg::WEIGHT_W] = 4'($urandom);
      write_reg(ghi_pkg::REG_FILTER_WEIGHT, setting);
      case ($urandom_range(5))
        0:       setting = '0;
        1:       setting = 20'h07FFF;
        2:       setting = 20'($urandom_range(32767));
        default: setting = 20'($urandom_range(300));
      endcase
      setting[ghi_pkg::CFG_DAT_W-1:ghi_pkg::DBAND_W] = 5'($urandom);
      write_reg(ghi_pkg::REG_DEAD_BAND, setting);
      case ($urandom_range(5))
        0:       setting = '0;
        1:       setting = 20'hFFFFF;
        2:       setting = 20'h00001;
        3:       setting = 20'($urandom);
        default: setting = 20'($urandom_range(1000000, 1));
      endcase
      write_reg(ghi_pkg::REG_DEFAULT_INTERVAL, setting);
      if ($urandom_range(1) != 0) write_reg(REG_UNUSED, 20'($urandom));

      // Leave one side fully busy in some phases so back-to-back traffic
      // and steady draining both get time.
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(60, 10);
      gap_pct   = (p % 3 == 1) ? 0 : $urandom_range(60, 10);

      for (n = 0; n < PHASE_SAMPLES; n++) begin
        case ($urandom_range(9))
          0:       rate = 16'sh7FFF;
          1:       rate = 16'sh8000;
          2, 3:    rate = ghi_pkg::RATE_W'(int'($urandom_range(400)) - 200);  // near dead band
          default: rate = ghi_pkg::RATE_W'($urandom);
        endcase
        case ($urandom_range(19))
          0:       stamp = prev_stamp;                                  // repeated timestamp
          1:       stamp = $urandom;                                    // arbitrary jump
          2:       stamp = '1 - ghi_pkg::TIME_W'($urandom_range(3000)); // just under the wrap
          default: stamp = prev_stamp + ghi_pkg::TIME_W'($urandom_range(3000, 1));
        endcase
        gap = 0;
        if ($urandom_range(99) < gap_pct)
          gap = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
        send_sample(rate, stamp, gap, 1'b0, fixed);
      end
    end

    // Full-scale rates over the longest possible interval (timestamp one
    // behind the last), first positive then negative, with the filter
    // following the sample at once and no dead band.
    wait_until_drained();
    write_reg(ghi_pkg::REG_FILTER_WEIGHT, 20'h0FFFF);
    write_reg(ghi_pkg::REG_DEAD_BAND, '0);
    stall_pct = 0;
    for (n = 0; n < 8; n++)
      send_sample((n < 4) ? 16'sh7FFF : 16'sh8000, prev_stamp - 1, 0, 1'b0, fixed);

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #6_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== gyro_heading_integrator.f =====
design/ghi_pkg.sv
design/ghi_mul.sv
design/ghi_ctrl.sv
design/gyro_heading_integrator.sv
dv/tb_top.sv
